[hdl/lps_pkg.sv]
package lps_pkg;

    localparam int PHASES_DEF        = 4;
    localparam int DURATION_BITS_DEF = 15;
    localparam int COUNT_BITS        = 2;
    localparam int CNT_W             = COUNT_BITS + 1;
    localparam int NUM_PATTERNS      = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CMD_W             = 3;
    localparam int MODE_W            = 3;
    localparam int TIME_W            = 32;
    localparam int PAT_W_DEF         = PHASES_DEF * DURATION_BITS_DEF + COUNT_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_SELECT    = 3'd1,
        CMD_FORCE_ON  = 3'd2,
        CMD_FORCE_OFF = 3'd3,
        CMD_TIMEOUT   = 3'd4
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_INACTIVE  = 3'd0,
        MODE_BREATHE   = 3'd1,
        MODE_HEARTBEAT = 3'd2,
        MODE_FLASH     = 3'd3,
        MODE_STROBE    = 3'd4,
        MODE_BLINK     = 3'd5,
        MODE_TIMEOUT   = 3'd6
    } t_mode;

    typedef struct packed {
        logic  led_on;
        t_mode active_mode;
    } t_result;

    // code seven falls back to inactive
    function automatic t_mode clean_mode(input logic [MODE_W-1:0] m);
        t_mode res;
        if (m == 3'd7) begin
            res = MODE_INACTIVE;
        end else begin
            res = t_mode'(m);
        end
        return res;
    endfunction

endpackage

[hdl/lps_if.sv]
interface lps_in_if;
    logic                        valid;
    logic                        ready;
    logic [lps_pkg::CMD_W-1:0]   command;
    logic [lps_pkg::MODE_W-1:0]  mode;
    logic [lps_pkg::TIME_W-1:0]  timeout_ms;

    modport source (output valid, command, mode, timeout_ms, input ready);
    modport sink   (input valid, command, mode, timeout_ms, output ready);
endinterface

interface lps_out_if;
    logic                        valid;
    logic                        ready;
    logic                        led_on;
    logic [lps_pkg::MODE_W-1:0]  active_mode;

    modport source (output valid, led_on, active_mode, input ready);
    modport sink   (input valid, led_on, active_mode, output ready);
endinterface

interface lps_cfg_if #(
    parameter int DATA_W = lps_pkg::PAT_W_DEF
);
    logic                           valid;
    logic                           ready;
    logic [lps_pkg::CFG_IDX_W-1:0]  index;
    logic [DATA_W-1:0]              data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/lps_pattern_regs.sv]
module lps_pattern_regs #(
    parameter int PHASES        = lps_pkg::PHASES_DEF,
    parameter int DURATION_BITS = lps_pkg::DURATION_BITS_DEF,
    parameter int PAT_W         = PHASES * DURATION_BITS + lps_pkg::COUNT_BITS,
    parameter int IDX_W         = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [lps_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [PAT_W-1:0]                i_wr_data,
    input  lps_pkg::t_mode                  i_mode,
    input  logic [IDX_W-1:0]                i_phase,
    output logic [DURATION_BITS-1:0]        o_duration,
    output logic [lps_pkg::CNT_W-1:0]       o_count
);
    import lps_pkg::*;

    localparam int MAX_CNT = (PHASES < 4) ? PHASES : 4;

    logic [PAT_W-1:0] r_pattern [NUM_PATTERNS];
    logic [PAT_W-1:0] sel_pattern;
    logic [CNT_W-1:0] raw_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PATTERNS; i++) begin
                r_pattern[i] <= '0;
            end
        end else if (i_wr_en && (i_wr_index < CFG_IDX_W'(NUM_PATTERNS))) begin
            r_pattern[i_wr_index[1:0]] <= i_wr_data;
        end
    end

    always_comb begin
        case (i_mode)
            MODE_HEARTBEAT: sel_pattern = r_pattern[0];
            MODE_FLASH:     sel_pattern = r_pattern[1];
            MODE_STROBE:    sel_pattern = r_pattern[2];
            MODE_BLINK:     sel_pattern = r_pattern[3];
            default:        sel_pattern = r_pattern[0];
        endcase
    end

    always_comb begin
        o_duration = '0;
        for (int k = 0; k < MAX_CNT; k++) begin
            if (i_phase == IDX_W'(k)) begin
                o_duration = sel_pattern[k*DURATION_BITS +: DURATION_BITS];
            end
        end
    end

    // phase count field holds count minus one, clipped to the table size
    always_comb begin
        raw_count = CNT_W'(sel_pattern[PHASES*DURATION_BITS +: COUNT_BITS]) + CNT_W'(1);
        if (raw_count > CNT_W'(MAX_CNT)) begin
            o_count = CNT_W'(MAX_CNT);
        end else begin
            o_count = raw_count;
        end
    end

endmodule

[hdl/lps_engine.sv]
module lps_engine #(
    parameter int DURATION_BITS = lps_pkg::DURATION_BITS_DEF,
    parameter int IDX_W         = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lps_in_if.sink                          i_in,
    input  logic                            i_res_full,
    output logic                            o_res_push,
    output lps_pkg::t_result                o_res_data,
    output lps_pkg::t_mode                  o_mode,
    output logic [IDX_W-1:0]                o_phase,
    input  logic [DURATION_BITS-1:0]        i_duration,
    input  logic [lps_pkg::CNT_W-1:0]       i_count
);
    import lps_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // input register
    logic                r_in_valid;
    logic [CMD_W-1:0]    r_cmd;
    logic [MODE_W-1:0]   r_mode_in;
    logic [TIME_W-1:0]   r_time_in;

    // block state
    t_mode               r_mode,    n_mode;
    logic [IDX_W-1:0]    r_phase,   n_phase;
    logic [TIME_W-1:0]   r_elapsed, n_elapsed;
    logic                r_led,     n_led;
    logic [TIME_W-1:0]   r_timeout, n_timeout;
    t_mode               r_follow,  n_follow;

    logic                advance;
    logic                in_ready;
    t_mode               sel_mode;
    logic [TIME_W-1:0]   elapsed_inc;
    logic [CNT_W-1:0]    phase_inc;

    assign advance    = r_in_valid && !i_res_full;
    assign in_ready   = !r_in_valid || !i_res_full;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_cmd     <= i_in.command;
            r_mode_in <= i_in.mode;
            r_time_in <= i_in.timeout_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_INACTIVE;
            r_phase   <= '0;
            r_elapsed <= '0;
            r_led     <= 1'b0;
            r_timeout <= '0;
            r_follow  <= MODE_INACTIVE;
        end else if (advance) begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_led     <= n_led;
            r_timeout <= n_timeout;
            r_follow  <= n_follow;
        end
    end

    assign sel_mode    = clean_mode(r_mode_in);
    assign elapsed_inc = (r_elapsed == TIME_MAX) ? r_elapsed : r_elapsed + TIME_W'(1);
    assign phase_inc   = CNT_W'(r_phase) + CNT_W'(1);

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_led     = r_led;
        n_timeout = r_timeout;
        n_follow  = r_follow;
        case (t_cmd'(r_cmd))
            CMD_TICK: begin
                n_elapsed = elapsed_inc;
                if (r_mode inside {[MODE_HEARTBEAT:MODE_BLINK]}) begin
                    if (elapsed_inc >= TIME_W'(i_duration)) begin
                        n_elapsed = '0;
                        if (phase_inc >= i_count) begin
                            n_phase = '0;
                        end else begin
                            n_phase = phase_inc[IDX_W-1:0];
                        end
                        n_led = ~n_phase[0];
                    end
                end else if (r_mode == MODE_TIMEOUT) begin
                    if (elapsed_inc >= r_timeout) begin
                        n_led = 1'b0;
                        // timeout chained to timeout keeps running with the led off
                        if (r_follow != MODE_TIMEOUT) begin
                            n_mode    = r_follow;
                            n_phase   = '0;
                            n_elapsed = '0;
                            if (r_follow != MODE_INACTIVE) begin
                                n_led = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_SELECT: begin
                if (sel_mode != r_mode) begin
                    n_mode    = sel_mode;
                    n_phase   = '0;
                    n_elapsed = '0;
                    if (sel_mode != MODE_INACTIVE) begin
                        n_led = 1'b1;
                    end
                end
            end
            CMD_FORCE_ON: begin
                n_mode = MODE_INACTIVE;
                n_led  = 1'b1;
            end
            CMD_FORCE_OFF: begin
                n_mode = MODE_INACTIVE;
                n_led  = 1'b0;
            end
            CMD_TIMEOUT: begin
                n_timeout = r_time_in;
                n_follow  = sel_mode;
                if (r_mode != MODE_TIMEOUT) begin
                    n_mode    = MODE_TIMEOUT;
                    n_phase   = '0;
                    n_elapsed = '0;
                    n_led     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res_push             = advance;
    assign o_res_data.led_on      = n_led;
    assign o_res_data.active_mode = n_mode;
    assign o_mode                 = r_mode;
    assign o_phase                = r_phase;

endmodule

[hdl/lps_result_buf.sv]
module lps_result_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lps_pkg::t_result    i_data,
    output logic                o_full,
    lps_out_if.source           o_out
);
    import lps_pkg::*;

    localparam int DEPTH = 2;

    t_result           r_data [DEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              pop;
    logic              push;

    assign o_full = (r_count == 2'(DEPTH));
    assign push   = i_push && !o_full;
    assign pop    = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_out.valid       = (r_count != '0);
    assign o_out.led_on      = r_data[r_rd_ptr].led_on;
    assign o_out.active_mode = r_data[r_rd_ptr].active_mode;

endmodule

[hdl/led_pattern_sequencer_top.sv]
// channel   dir  handshake          word
// i_in      in   valid/ready        command, mode, timeout_ms
// o_out     out  valid/ready        led_on, active_mode (one word per input word)
// i_cfg     in   valid/ready        index, data (pattern registers 0..3)
//
// one input word per cycle sustained while the result buffer is not full; each word
// is held in the input register, where its state update and result are formed
// synchronous active-low reset clears state, patterns and the result buffer
// a two-word result buffer decouples o_out stalls; input stalls only when it is full
// i_cfg is always ready
module led_pattern_sequencer_top #(
    parameter int PHASES        = lps_pkg::PHASES_DEF,
    parameter int DURATION_BITS = lps_pkg::DURATION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lps_in_if.sink      i_in,
    lps_out_if.source   o_out,
    lps_cfg_if.sink     i_cfg
);
    import lps_pkg::*;

    localparam int PAT_W   = PHASES * DURATION_BITS + COUNT_BITS;
    localparam int MAX_CNT = (PHASES < 4) ? PHASES : 4;
    localparam int IDX_W   = $clog2(MAX_CNT);

    t_mode                      cur_mode;
    logic [IDX_W-1:0]           cur_phase;
    logic [DURATION_BITS-1:0]   duration;
    logic [CNT_W-1:0]           count;
    logic                       res_full;
    logic                       res_push;
    t_result                    res_data;

    assign i_cfg.ready = 1'b1;

    lps_pattern_regs #(
        .PHASES        (PHASES),
        .DURATION_BITS (DURATION_BITS),
        .PAT_W         (PAT_W),
        .IDX_W         (IDX_W)
    ) u_patterns (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (PAT_W'(i_cfg.data)),
        .i_mode     (cur_mode),
        .i_phase    (cur_phase),
        .o_duration (duration),
        .o_count    (count)
    );

    lps_engine #(
        .DURATION_BITS (DURATION_BITS),
        .IDX_W         (IDX_W)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_data (res_data),
        .o_mode     (cur_mode),
        .o_phase    (cur_phase),
        .i_duration (duration),
        .i_count    (count)
    );

    lps_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .o_out   (o_out)
    );

endmodule

[sim/lps_led_checker.sv]
`timescale 1ns / 1ps

module lps_led_checker
    import lps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [TIME_W-1:0]     i_timeout_ms,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_led_on,
    input  logic [MODE_W-1:0]     i_active_mode,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [PAT_W_DEF-1:0]  i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    localparam int MAX_REPORTS = 40;

    logic [PAT_W_DEF-1:0] pattern_regs [NUM_PATTERNS];
    t_mode                cur_mode;
    t_mode                follow_mode;
    logic [1:0]           phase_idx;
    logic [TIME_W-1:0]    elapsed_ms;
    logic [TIME_W-1:0]    timeout_len;
    logic                 led_level;
    t_result              expected_leds [$];
    int                   mismatches = 0;

    function automatic t_mode legal_mode(input logic [MODE_W-1:0] m);
        return (m > MODE_TIMEOUT) ? MODE_INACTIVE : t_mode'(m);
    endfunction

    task automatic switch_mode(input t_mode m);
        if (m != cur_mode) begin
            cur_mode   = m;
            phase_idx  = '0;
            elapsed_ms = '0;
            if (m != MODE_INACTIVE) begin
                led_level = 1'b1;
            end
        end
    endtask

    task automatic tick_ms();
        logic [PAT_W_DEF-1:0]         pat;
        logic [DURATION_BITS_DEF-1:0] dur;
        logic [1:0]                   slot;
        int                           count;
        int                           nxt;
        if (elapsed_ms != '1) begin
            elapsed_ms++;
        end
        if (cur_mode >= MODE_HEARTBEAT && cur_mode <= MODE_BLINK) begin
            slot  = 2'(cur_mode - MODE_HEARTBEAT);
            pat   = pattern_regs[slot];
            dur   = pat[phase_idx * DURATION_BITS_DEF +: DURATION_BITS_DEF];
            count = int'(pat[PHASES_DEF * DURATION_BITS_DEF +: COUNT_BITS]) + 1;
            if (elapsed_ms >= dur) begin
                elapsed_ms = '0;
                nxt = int'(phase_idx) + 1;
                // a shortened pattern wraps the index on the next advance
                phase_idx = (nxt >= count) ? 2'd0 : nxt[1:0];
                led_level = ~phase_idx[0];
            end
        end else if (cur_mode == MODE_TIMEOUT) begin
            if (elapsed_ms >= timeout_len) begin
                led_level = 1'b0;
                switch_mode(follow_mode);
            end
        end
    endtask

    task automatic apply_word(input logic [CMD_W-1:0] cmd, input logic [MODE_W-1:0] mode_raw,
                              input logic [TIME_W-1:0] tmo);
        t_mode   m;
        t_result r;
        m = legal_mode(mode_raw);
        case (cmd)
            CMD_TICK: begin
                tick_ms();
            end
            CMD_SELECT: begin
                switch_mode(m);
            end
            CMD_FORCE_ON: begin
                cur_mode  = MODE_INACTIVE;
                led_level = 1'b1;
            end
            CMD_FORCE_OFF: begin
                cur_mode  = MODE_INACTIVE;
                led_level = 1'b0;
            end
            CMD_TIMEOUT: begin
                timeout_len = tmo;
                follow_mode = m;
                switch_mode(MODE_TIMEOUT);
            end
            default: begin
            end
        endcase
        r.led_on      = led_level;
        r.active_mode = cur_mode;
        expected_leds.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (pattern_regs[k]) begin
                pattern_regs[k] = '0;
            end
            cur_mode    = MODE_INACTIVE;
            follow_mode = MODE_INACTIVE;
            phase_idx   = '0;
            elapsed_ms  = '0;
            timeout_len = '0;
            led_level   = 1'b0;
            expected_leds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_PATTERNS) begin
                pattern_regs[i_cfg_index[1:0]] = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                apply_word(i_command, i_mode, i_timeout_ms);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_leds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: unexpected word: expected none, actual led_on %0b mode %0d",
                                 $time, i_led_on, i_active_mode);
                    end
                end else begin
                    want = expected_leds.pop_front();
                    if (want.led_on !== i_led_on) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: led_on mismatch: expected %0b actual %0b",
                                     $time, want.led_on, i_led_on);
                        end
                    end
                    if (want.active_mode !== i_active_mode) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: active_mode mismatch: expected %0d actual %0d",
                                     $time, want.active_mode, i_active_mode);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_leds.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import lps_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int NUM_PHASES      = 6;
    localparam int WORDS_PER_PHASE = 150;
    localparam int PRESSURE_AFTER  = 200;
    localparam int PRESSURE_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STROBE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] PATTERN_REG [NUM_PATTERNS] =
        '{REG_HEARTBEAT, REG_FLASH, REG_STROBE, REG_BLINK};

    // spare command codes and the out-of-range mode code
    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SEVEN   = 3'd7;

    // four one-ms phases, then the same trimmed to two phases
    localparam logic [PAT_W_DEF-1:0] FOUR_SHORT = {2'd3, 15'd1, 15'd1, 15'd1, 15'd1};
    localparam logic [PAT_W_DEF-1:0] TWO_SHORT  = {2'd1, 15'd1, 15'd1, 15'd1, 15'd1};

    typedef enum int {PAT_ZERO, PAT_FULL, PAT_SHORT, PAT_WILD} t_pat_style;

    logic clk;
    logic rst_n;
    int   words_sent = 0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   mismatch_count;
    int   pending_count;

    lps_in_if  in_ch ();
    lps_out_if out_ch ();
    lps_cfg_if cfg_ch ();

    led_pattern_sequencer_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lps_led_checker led_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_command     (in_ch.command),
        .i_mode        (in_ch.mode),
        .i_timeout_ms  (in_ch.timeout_ms),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_led_on      (out_ch.led_on),
        .i_active_mode (out_ch.active_mode),
        .i_cfg_valid   (cfg_ch.valid),
        .i_cfg_ready   (cfg_ch.ready),
        .i_cfg_index   (cfg_ch.index),
        .i_cfg_data    (cfg_ch.data),
        .o_mismatches  (mismatch_count),
        .o_outstanding (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("[led_pattern_sequencer_top] ERROR");
        $finish;
    end

    // result side: random stalls plus one long hold-off to fill the block
    initial begin
        bit pressed;
        pressed = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!pressed && words_sent >= PRESSURE_AFTER) begin
                pressed = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                out_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < snk_idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // leaves valid high; the caller lowers it once no word follows
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [MODE_W-1:0] m,
                             input logic [TIME_W-1:0] tmo);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.mode       <= m;
        in_ch.timeout_ms <= tmo;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_patterns(input logic [PAT_W_DEF-1:0] pats [NUM_PATTERNS]);
        for (int k = 0; k < NUM_PATTERNS; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= PATTERN_REG[k];
            cfg_ch.data  <= pats[k];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [PAT_W_DEF-1:0] make_pattern(input t_pat_style style);
        logic [PAT_W_DEF-1:0] p;
        case (style)
            PAT_ZERO: begin
                p = '0;
            end
            PAT_FULL: begin
                p = '1;
            end
            PAT_SHORT: begin
                p = '0;
                for (int k = 0; k < PHASES_DEF; k++) begin
                    p[k * DURATION_BITS_DEF +: DURATION_BITS_DEF] =
                        DURATION_BITS_DEF'($urandom_range(0, 4));
                end
                p[PHASES_DEF * DURATION_BITS_DEF +: COUNT_BITS] =
                    COUNT_BITS'($urandom_range(0, 3));
            end
            default: begin
                p = PAT_W_DEF'({$urandom, $urandom});
            end
        endcase
        return p;
    endfunction

    // mostly ticks so patterns and timeouts actually run through their phases
    task automatic send_random_word();
        int                  pick;
        logic [CMD_W-1:0]    cmd;
        logic [MODE_W-1:0]   m;
        logic [TIME_W-1:0]   tmo;
        pick = $urandom_range(0, 99);
        m    = MODE_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: tmo = $urandom_range(0, 6);
            7, 8:                tmo = $urandom_range(0, 60);
            default:             tmo = $urandom;
        endcase
        if (pick < 55) begin
            cmd = CMD_TICK;
        end else if (pick < 70) begin
            cmd = CMD_SELECT;
        end else if (pick < 80) begin
            cmd = CMD_TIMEOUT;
        end else if (pick < 86) begin
            cmd = CMD_FORCE_ON;
        end else if (pick < 92) begin
            cmd = CMD_FORCE_OFF;
        end else begin
            cmd = CMD_W'($urandom);
        end
        send_word(cmd, m, tmo);
    endtask

    initial begin
        logic [PAT_W_DEF-1:0] pats [NUM_PATTERNS];
        int                   style_pick;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_TICK;
        in_ch.mode       <= MODE_INACTIVE;
        in_ch.timeout_ms <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_HEARTBEAT;
        cfg_ch.data      <= '0;
        rst_n            <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, patterns still at their reset value of zero
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        send_word(CMD_SELECT, MODE_BREATHE, '0);
        send_word(CMD_SELECT, MODE_BREATHE, '0);
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        send_word(CMD_SELECT, MODE_HEARTBEAT, '0);
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        send_word(CMD_SELECT, MODE_FLASH, '0);
        send_word(CMD_SELECT, MODE_STROBE, '0);
        send_word(CMD_SELECT, MODE_BLINK, '0);
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        send_word(CMD_FORCE_ON, MODE_HEARTBEAT, '0);
        send_word(CMD_FORCE_OFF, MODE_HEARTBEAT, '0);
        send_word(CMD_SELECT, MODE_SEVEN, '0);
        // timeout that follows into timeout again
        send_word(CMD_TIMEOUT, MODE_TIMEOUT, '0);
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        // restart while already in timeout only updates the stored values
        send_word(CMD_TIMEOUT, MODE_SEVEN, 32'd2);
        send_word(CMD_TICK, MODE_INACTIVE, '0);
        send_word(CMD_SELECT, MODE_TIMEOUT, '0);
        send_word(CMD_SPARE_LO, MODE_SEVEN, '1);
        send_word(CMD_SPARE_HI, MODE_SEVEN, '1);
        send_word(CMD_TIMEOUT, MODE_HEARTBEAT, '1);
        send_word(CMD_FORCE_OFF, MODE_INACTIVE, '0);

        // pattern trimmed while the phase index sits past the new count
        drain_results();
        pats = '{FOUR_SHORT, '0, '0, '0};
        load_patterns(pats);
        send_word(CMD_SELECT, MODE_HEARTBEAT, '0);
        repeat (3) send_word(CMD_TICK, MODE_INACTIVE, '0);
        drain_results();
        pats = '{TWO_SHORT, '0, '0, '0};
        load_patterns(pats);
        repeat (2) send_word(CMD_TICK, MODE_INACTIVE, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            for (int k = 0; k < NUM_PATTERNS; k++) begin
                style_pick = $urandom_range(0, 9);
                if (ph == 1) begin
                    pats[k] = make_pattern(PAT_FULL);
                end else if (ph == 2) begin
                    pats[k] = make_pattern(PAT_ZERO);
                end else if (ph == 0 || style_pick < 6) begin
                    pats[k] = make_pattern(PAT_SHORT);
                end else if (style_pick < 8) begin
                    pats[k] = make_pattern(PAT_WILD);
                end else begin
                    pats[k] = make_pattern(style_pick == 8 ? PAT_ZERO : PAT_FULL);
                end
            end
            load_patterns(pats);
            // no idling at all in the closing phase
            if (ph == NUM_PHASES - 1) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = $urandom_range(0, 2) * 15;
                snk_idle_pct = $urandom_range(0, 2) * 15;
            end
            repeat (WORDS_PER_PHASE) send_random_word();
        end

        drain_results();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("[led_pattern_sequencer_top] OK");
        end else begin
            $display("[led_pattern_sequencer_top] ERROR");
        end
        $finish;
    end

endmodule
